// File: rtl/core/jndg_pkg.sv
// Package for the JSON nesting depth gate: character codes, status codes and
// default sizes shared by the gate and its checker. No dependencies.
package jndg_pkg;

    localparam int unsigned LEVEL_WIDTH_DEFAULT = 11;
    localparam int unsigned LIMIT_WIDTH = 10;
    localparam int unsigned DEEPEST_WIDTH = 11;
    localparam int unsigned HEX_SKIP_WIDTH = 3;

    localparam logic [LIMIT_WIDTH-1:0] DEPTH_LIMIT_RESET = 10'd256;
    localparam logic [HEX_SKIP_WIDTH-1:0] HEX_DIGITS = 3'd4;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_U = 8'h75;
    localparam logic [7:0] CHAR_OPEN_BRACE = 8'h7B;
    localparam logic [7:0] CHAR_OPEN_BRACKET = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] CHAR_CLOSE_BRACKET = 8'h5D;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_DEPTH = 2'd1,
        STATUS_UNTERM = 2'd2
    } status_t;

endpackage

// File: rtl/core/json_nesting_depth_gate_unit.sv
// JSON nesting depth gate: screens a document one byte per item and reports
// a verdict with the deepest nesting level. Depends on jndg_pkg.
//
//  channel  | handshake                   | fields
//  ---------+-----------------------------+--------------------------------
//  input    | in_valid / in_ready         | data_byte, byte_valid, last
//  result   | out_valid / out_ready       | status, deepest
//  config   | cfg_write_en (no wait)      | cfg_write_data (depth limit)
//
// One item per cycle unless a result is stalled: an accepted item is held in
// the input register, and the scan state and the result register update from it.
// A result passes the input register and then the result register.
// Reset clears the scan state and sets the depth limit to 256.
// A stalled result holds the input register; input accepts whenever the
// result register is empty or being taken.
module json_nesting_depth_gate_unit #(
    parameter int unsigned LEVEL_WIDTH = jndg_pkg::LEVEL_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           data_byte,
    input  logic                                 byte_valid,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic [jndg_pkg::DEEPEST_WIDTH-1:0]   deepest,
    input  logic                                 cfg_write_en,
    input  logic [jndg_pkg::LIMIT_WIDTH-1:0]     cfg_write_data
);
    import jndg_pkg::*;

    localparam int unsigned CMP_WIDTH = LEVEL_WIDTH + LIMIT_WIDTH;
    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = {LEVEL_WIDTH{1'b1}};

    logic [LIMIT_WIDTH-1:0]     depth_limit_reg;

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_byte_valid_reg;
    logic                       s1_last_reg;

    logic                       inside_string_reg, inside_string_next;
    logic                       escape_pending_reg, escape_pending_next;
    logic [HEX_SKIP_WIDTH-1:0]  hex_skip_reg, hex_skip_next;
    logic [LEVEL_WIDTH-1:0]     nest_level_reg, nest_level_next;
    logic [LEVEL_WIDTH-1:0]     peak_level_reg, peak_level_next;
    logic                       verdict_given_reg, verdict_given_next;

    logic                       out_valid_reg, out_valid_next;
    status_t                    status_reg, status_next;
    logic [DEEPEST_WIDTH-1:0]   deepest_reg, deepest_next;

    logic                       advance;
    logic                       process;
    logic [LEVEL_WIDTH-1:0]     level_up;
    logic [CMP_WIDTH-1:0]       level_up_wide;
    logic [CMP_WIDTH-1:0]       limit_wide;
    logic [CMP_WIDTH+DEEPEST_WIDTH-1:0] peak_wide;

    assign advance = !out_valid_reg || out_ready;
    assign process = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    assign level_up = (nest_level_reg != LEVEL_MAX) ? nest_level_reg + 1'b1 : nest_level_reg;
    assign level_up_wide = {{LIMIT_WIDTH{1'b0}}, level_up};
    assign limit_wide = {{LEVEL_WIDTH{1'b0}}, depth_limit_reg};

    always_comb
    begin
        inside_string_next = inside_string_reg;
        escape_pending_next = escape_pending_reg;
        hex_skip_next = hex_skip_reg;
        nest_level_next = nest_level_reg;
        peak_level_next = peak_level_reg;
        verdict_given_next = verdict_given_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        deepest_next = deepest_reg;
        peak_wide = '0;

        if (process)
        begin
            if (s1_byte_valid_reg && !verdict_given_reg)
            begin
                if (inside_string_reg)
                begin
                    priority if (hex_skip_reg != '0)
                    begin
                        hex_skip_next = hex_skip_reg - 1'b1;
                    end
                    else if (escape_pending_reg)
                    begin
                        escape_pending_next = 1'b0;
                        if (s1_byte_reg == CHAR_U)
                        begin
                            hex_skip_next = HEX_DIGITS;
                        end
                    end
                    else if (s1_byte_reg == CHAR_QUOTE)
                    begin
                        inside_string_next = 1'b0;
                    end
                    else if (s1_byte_reg == CHAR_BACKSLASH)
                    begin
                        escape_pending_next = 1'b1;
                    end
                    else
                    begin
                        inside_string_next = inside_string_reg;
                    end
                end
                else
                begin
                    priority if (s1_byte_reg == CHAR_QUOTE)
                    begin
                        inside_string_next = 1'b1;
                    end
                    else if (s1_byte_reg == CHAR_OPEN_BRACE || s1_byte_reg == CHAR_OPEN_BRACKET)
                    begin
                        nest_level_next = level_up;
                        if (level_up > peak_level_reg)
                        begin
                            peak_level_next = level_up;
                        end
                        if (level_up_wide > limit_wide)
                        begin
                            verdict_given_next = 1'b1;
                            out_valid_next = 1'b1;
                            status_next = STATUS_DEPTH;
                        end
                    end
                    else if (s1_byte_reg == CHAR_CLOSE_BRACE
                             || s1_byte_reg == CHAR_CLOSE_BRACKET)
                    begin
                        if (nest_level_reg != '0)
                        begin
                            nest_level_next = nest_level_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        nest_level_next = nest_level_reg;
                    end
                end
            end

            if (s1_last_reg && !verdict_given_next)
            begin
                out_valid_next = 1'b1;
                status_next = inside_string_next ? STATUS_UNTERM : STATUS_OK;
            end

            peak_wide = {{(CMP_WIDTH+DEEPEST_WIDTH-LEVEL_WIDTH){1'b0}}, peak_level_next};
            if (out_valid_next && !(out_valid_reg && !out_ready))
            begin
                deepest_next = peak_wide[DEEPEST_WIDTH-1:0];
            end

            if (s1_last_reg)
            begin
                inside_string_next = 1'b0;
                escape_pending_next = 1'b0;
                hex_skip_next = '0;
                nest_level_next = '0;
                peak_level_next = '0;
                verdict_given_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= DEPTH_LIMIT_RESET;
            s1_valid_reg <= 1'b0;
            inside_string_reg <= 1'b0;
            escape_pending_reg <= 1'b0;
            hex_skip_reg <= '0;
            nest_level_reg <= '0;
            peak_level_reg <= '0;
            verdict_given_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                depth_limit_reg <= cfg_write_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            inside_string_reg <= inside_string_next;
            escape_pending_reg <= escape_pending_next;
            hex_skip_reg <= hex_skip_next;
            nest_level_reg <= nest_level_next;
            peak_level_reg <= peak_level_next;
            verdict_given_reg <= verdict_given_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_byte_valid_reg <= byte_valid;
            s1_last_reg <= last;
        end
        status_reg <= status_next;
        deepest_reg <= deepest_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign deepest = deepest_reg;

endmodule

// File: rtl/core/jndg_checker.sv
// Port-level checker for the JSON nesting depth gate, bound to the gate module.
// Depends on jndg_pkg and json_nesting_depth_gate_unit.
module jndg_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         status,
    input logic [jndg_pkg::DEEPEST_WIDTH-1:0] deepest
);
    import jndg_pkg::*;

    // A result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(deepest))
    else $error("stalled result changed");

    // Input is only held off while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !out_ready) |-> in_ready)
    else $error("input stalled without a waiting result");

    // An offered item stays offered until it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before acceptance");

    // A depth verdict always carries a level above zero and at most one past the limit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_DEPTH |-> deepest != '0 && deepest <= 11'd1024)
    else $error("depth verdict with impossible level");

endmodule

bind json_nesting_depth_gate_unit jndg_checker u_jndg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .deepest   (deepest)
);
